[hw/rtl/mlp_pkg.sv]
// Package for the perceptron inference core: payload structs, opcodes,
// the base-2 exp table. No dependencies.
package mlp_pkg;

    localparam logic [1:0] MODE_WEIGHT = 2'd0;
    localparam logic [1:0] MODE_BIAS   = 2'd1;
    localparam logic [1:0] MODE_PIXEL  = 2'd2;

    localparam logic [1:0] LAYER_H1  = 2'd0;
    localparam logic [1:0] LAYER_H2  = 2'd1;
    localparam logic [1:0] LAYER_OUT = 2'd2;

    localparam logic [12:0] LOG2E_Q12 = 13'd5909;

    typedef struct packed {
        logic [1:0]         mode;
        logic [1:0]         layer;
        logic [9:0]         row;
        logic [3:0]         col;
        logic signed [15:0] value;
        logic               last;
    } mlp_in_t;

    typedef struct packed {
        logic [3:0]  class_index;
        logic [15:0] probability;
        logic        final_res;
    } mlp_out_t;

    // request to the shared divider
    typedef struct packed {
        logic        go;
        logic [31:0] num;
        logic [35:0] den;
    } mlp_div_req_t;

    typedef struct packed {
        logic        done;
        logic [16:0] quo;
    } mlp_div_rsp_t;

    function automatic logic [16:0] pow2_tab(input logic [5:0] j);
        logic [16:0] r;
        begin
            case (j)
                6'd0:  r = 17'd65536; 6'd1:  r = 17'd64132; 6'd2:  r = 17'd62757;
                6'd3:  r = 17'd61413; 6'd4:  r = 17'd60097; 6'd5:  r = 17'd58809;
                6'd6:  r = 17'd57549; 6'd7:  r = 17'd56316; 6'd8:  r = 17'd55109;
                6'd9:  r = 17'd53928; 6'd10: r = 17'd52773; 6'd11: r = 17'd51642;
                6'd12: r = 17'd50535; 6'd13: r = 17'd49452; 6'd14: r = 17'd48393;
                6'd15: r = 17'd47356; 6'd16: r = 17'd46341; 6'd17: r = 17'd45348;
                6'd18: r = 17'd44376; 6'd19: r = 17'd43425; 6'd20: r = 17'd42495;
                6'd21: r = 17'd41584; 6'd22: r = 17'd40693; 6'd23: r = 17'd39821;
                6'd24: r = 17'd38968; 6'd25: r = 17'd38133; 6'd26: r = 17'd37316;
                6'd27: r = 17'd36516; 6'd28: r = 17'd35734; 6'd29: r = 17'd34968;
                6'd30: r = 17'd34219; 6'd31: r = 17'd33486;
                default: r = 17'd32768;
            endcase
            return r;
        end
    endfunction

endpackage

[hw/rtl/mlp_div.sv]
// Restoring divider, one quotient bit per cycle: (num*65536 + den/2) / den,
// 17-bit quotient. Depends on mlp_pkg.
module mlp_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mlp_pkg::mlp_div_req_t req,
    output mlp_pkg::mlp_div_rsp_t rsp
);
    import mlp_pkg::*;

    // dividend is below 2^49, quotient is at most 2^16 + 1; one step per dividend bit
    logic [48:0] dvd_reg;
    logic [35:0] den_reg;
    logic [36:0] rem_reg;
    logic [16:0] quo_reg;
    logic [5:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;
    logic [36:0] trial;
    logic [36:0] shifted;

    always_comb
    begin
        shifted = {rem_reg[35:0], dvd_reg[48]};
        trial   = shifted - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd48)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // 49 steps walk every dividend bit; only the low 17 quotient bits are kept
    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            dvd_reg <= {1'b0, req.num, 16'd0} + {14'd0, req.den[35:1]};
            den_reg <= req.den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (run_reg)
        begin
            dvd_reg <= {dvd_reg[47:0], 1'b0};
            if (!trial[36])
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[15:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[15:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule

[hw/rtl/mlp_forward_inference_core.sv]
// Top level of the perceptron inference core: weight, bias and pixel
// memories, one shared multiply-accumulate unit and the sequencer.
// Depends on mlp_pkg and mlp_div.
//
//  channel  | ports                          | transfer
//  ---------+--------------------------------+--------------------------
//  command  | start, busy, cmd (mlp_in_t)    | start && !busy
//  result   | res_valid, res (mlp_out_t)     | res_valid, one cycle each
//
// A pixel with last set starts the pass: one MAC per cycle over every weight,
// each neuron followed by a drain and a writeback step, then a max search over
// the C class sums, an exp for each class in two steps, then C divisions, one
// per class, on the shared divider and a closing step.
// busy stays high until the last result.
// Reset clears the biases and control state; weights and pixels are undefined
// until written. The receiver cannot stall results.
module mlp_forward_inference_core #(
    parameter int INPUT_COUNT      = 784,
    parameter int HIDDEN_ONE_COUNT = 16,
    parameter int HIDDEN_TWO_COUNT = 16,
    parameter int CLASS_COUNT      = 10,
    parameter int VALUE_BITS       = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  mlp_pkg::mlp_in_t cmd,
    output logic             busy,
    output logic             res_valid,
    output mlp_pkg::mlp_out_t res
);
    import mlp_pkg::*;

    localparam int IB  = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
    localparam int H1B = (HIDDEN_ONE_COUNT > 1) ? $clog2(HIDDEN_ONE_COUNT) : 1;
    localparam int H2B = (HIDDEN_TWO_COUNT > 1) ? $clog2(HIDDEN_TWO_COUNT) : 1;
    localparam int CB  = $clog2(CLASS_COUNT);
    localparam int W1D = INPUT_COUNT * HIDDEN_ONE_COUNT;
    localparam int W2D = HIDDEN_ONE_COUNT * HIDDEN_TWO_COUNT;
    localparam int W3D = HIDDEN_TWO_COUNT * CLASS_COUNT;
    localparam int W1B = $clog2(W1D);
    localparam int W2B = (W2D > 1) ? $clog2(W2D) : 1;
    localparam int W3B = $clog2(W3D);
    localparam int NB  = 7;   // destination counter covers up to 127 neurons
    localparam int SB  = 11;  // source counter covers up to 2047 inputs
    // multiplier operand: a pixel or an activation, plus a sign bit
    localparam int MW  = (VALUE_BITS > 16) ? VALUE_BITS + 1 : 17;
    // product plus growth over 1024 sources and the bias
    localparam int AW  = MW + 31;
    localparam logic [AW-1:0] CAP = AW'((64'd1 << (VALUE_BITS - 1)) - 64'd1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MAC  = 4'd1;
    localparam logic [3:0] ST_DRN  = 4'd2;
    localparam logic [3:0] ST_WB   = 4'd3;
    localparam logic [3:0] ST_MAX  = 4'd4;
    localparam logic [3:0] ST_EXP1 = 4'd5;
    localparam logic [3:0] ST_EXP2 = 4'd6;
    localparam logic [3:0] ST_DIV  = 4'd7;
    localparam logic [3:0] ST_DWT  = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    // memories
    logic signed [15:0] pix_mem [INPUT_COUNT];
    logic signed [15:0] w1_mem  [W1D];
    logic signed [15:0] w2_mem  [W2D];
    logic signed [15:0] w3_mem  [W3D];
    logic signed [15:0] pix_rd_reg, w1_rd_reg, w2_rd_reg, w3_rd_reg;

    logic signed [15:0] b1_reg [HIDDEN_ONE_COUNT];
    logic signed [15:0] b2_reg [HIDDEN_TWO_COUNT];
    logic signed [15:0] b3_reg [CLASS_COUNT];
    logic [VALUE_BITS-1:0] a1_reg [HIDDEN_ONE_COUNT];
    logic [VALUE_BITS-1:0] a2_reg [HIDDEN_TWO_COUNT];
    logic signed [AW-1:0] z_reg [CLASS_COUNT];
    logic [16:0] e_reg [CLASS_COUNT];

    logic [3:0]  state_reg;
    logic [1:0]  lay_reg;       // layer in progress
    logic [NB-1:0] k_reg;       // destination neuron
    logic [SB-1:0] i_reg;       // source index being issued
    logic        vld_reg;       // read data valid in this cycle
    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] zmax_reg;
    logic [35:0] tot_reg;
    logic [16:0] t_reg;         // exp argument, Q.12 (saturated)
    logic [CB-1:0] c_reg;
    logic [15:0] p_reg;
    logic        rv_reg;
    logic        fin_reg;
    logic [CB-1:0] ci_reg;

    logic        acc_in;
    logic [SB-1:0] src_cnt;
    logic [NB-1:0] dst_cnt;
    logic signed [MW-1:0] mul_a;
    logic signed [15:0] mul_b;
    logic signed [MW+15:0] prod;
    mlp_div_req_t dreq;
    mlp_div_rsp_t drsp;

    assign acc_in = start && !busy;

    // ---------------- writes ----------------
    always_ff @(posedge clk)
    begin
        if (acc_in)
        begin
            if (cmd.mode == MODE_WEIGHT && cmd.layer == LAYER_H1
                && 32'(cmd.row) < INPUT_COUNT && 32'(cmd.col) < HIDDEN_ONE_COUNT)
                w1_mem[W1B'(32'(cmd.row) * HIDDEN_ONE_COUNT + 32'(cmd.col))] <= cmd.value;
            if (cmd.mode == MODE_WEIGHT && cmd.layer == LAYER_H2
                && 32'(cmd.row) < HIDDEN_ONE_COUNT && 32'(cmd.col) < HIDDEN_TWO_COUNT)
                w2_mem[W2B'(32'(cmd.row) * HIDDEN_TWO_COUNT + 32'(cmd.col))] <= cmd.value;
            if (cmd.mode == MODE_WEIGHT && cmd.layer == LAYER_OUT
                && 32'(cmd.row) < HIDDEN_TWO_COUNT && 32'(cmd.col) < CLASS_COUNT)
                w3_mem[W3B'(32'(cmd.row) * CLASS_COUNT + 32'(cmd.col))] <= cmd.value;
            if (cmd.mode == MODE_PIXEL && 32'(cmd.row) < INPUT_COUNT)
                pix_mem[IB'(cmd.row)] <= cmd.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < HIDDEN_ONE_COUNT; n++) b1_reg[n] <= '0;
            for (int n = 0; n < HIDDEN_TWO_COUNT; n++) b2_reg[n] <= '0;
            for (int n = 0; n < CLASS_COUNT; n++)      b3_reg[n] <= '0;
        end
        else if (acc_in && cmd.mode == MODE_BIAS)
        begin
            for (int n = 0; n < HIDDEN_ONE_COUNT; n++)
                if (cmd.layer == LAYER_H1 && 32'(cmd.col) == n) b1_reg[n] <= cmd.value;
            for (int n = 0; n < HIDDEN_TWO_COUNT; n++)
                if (cmd.layer == LAYER_H2 && 32'(cmd.col) == n) b2_reg[n] <= cmd.value;
            for (int n = 0; n < CLASS_COUNT; n++)
                if (cmd.layer == LAYER_OUT && 32'(cmd.col) == n) b3_reg[n] <= cmd.value;
        end
    end

    // ---------------- reads for the MAC ----------------
    always_ff @(posedge clk)
    begin
        pix_rd_reg <= pix_mem[IB'(i_reg)];
        w1_rd_reg  <= w1_mem[W1B'(32'(i_reg) * HIDDEN_ONE_COUNT + 32'(k_reg))];
        w2_rd_reg  <= w2_mem[W2B'(32'(i_reg) * HIDDEN_TWO_COUNT + 32'(k_reg))];
        w3_rd_reg  <= w3_mem[W3B'(32'(i_reg) * CLASS_COUNT + 32'(k_reg))];
    end

    // source operand and index of the previous cycle's issue
    logic [SB-1:0] ip_reg;
    always_ff @(posedge clk) ip_reg <= i_reg;

    always_comb
    begin
        src_cnt = SB'(INPUT_COUNT);
        dst_cnt = NB'(HIDDEN_ONE_COUNT);
        mul_a   = MW'(pix_rd_reg);
        mul_b   = w1_rd_reg;
        case (lay_reg)
            LAYER_H2:
            begin
                src_cnt = SB'(HIDDEN_ONE_COUNT);
                dst_cnt = NB'(HIDDEN_TWO_COUNT);
                mul_a   = MW'($signed({1'b0, a1_reg[H1B'(ip_reg)]}));
                mul_b   = w2_rd_reg;
            end
            LAYER_OUT:
            begin
                src_cnt = SB'(HIDDEN_TWO_COUNT);
                dst_cnt = NB'(CLASS_COUNT);
                mul_a   = MW'($signed({1'b0, a2_reg[H2B'(ip_reg)]}));
                mul_b   = w3_rd_reg;
            end
            default: ;
        endcase
        prod = mul_a * mul_b;
    end

    // exp pipeline pieces
    logic [5:0]  ej;
    logic [6:0]  elo;
    logic [16:0] ta, tb;
    logic [23:0] dlt;
    logic [16:0] ev;
    logic [AW-1:0] dsub;
    logic [AW+13:0] tprod;
    assign dsub  = AW'(zmax_reg - z_reg[c_reg]);
    assign tprod = (AW+14)'(dsub) * (AW+14)'(LOG2E_Q12);
    assign ej    = {1'b0, t_reg[11:7]};
    assign elo   = t_reg[6:0];
    assign ta    = pow2_tab(ej);
    assign tb    = pow2_tab(ej + 6'd1);
    assign dlt   = 24'(ta - tb) * 24'(elo);
    assign ev    = ta - 17'(dlt >> 7);

    logic signed [15:0] bias_cur;
    always_comb
    begin
        case (lay_reg)
            LAYER_H1:  bias_cur = b1_reg[H1B'(k_reg)];
            LAYER_H2:  bias_cur = b2_reg[H2B'(k_reg)];
            default:   bias_cur = b3_reg[CB'(k_reg)];
        endcase
    end

    // bias added to the sum, then relu with rounding and saturation
    logic signed [AW-1:0] rsum;
    logic [AW-1:0] rr;
    logic [VALUE_BITS-1:0] relu_v;
    always_comb
    begin
        rsum = acc_reg + (AW'(bias_cur) <<< 12);
        rr = AW'(rsum + AW'(2048)) >> 12;
        if (rsum <= 0)       relu_v = '0;
        else if (rr > CAP)   relu_v = VALUE_BITS'(CAP);
        else                 relu_v = rr[VALUE_BITS-1:0];
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lay_reg   <= LAYER_H1;
            k_reg     <= '0;
            i_reg     <= '0;
            vld_reg   <= 1'b0;
            c_reg     <= '0;
            rv_reg    <= 1'b0;
            fin_reg   <= 1'b0;
            for (int n = 0; n < HIDDEN_ONE_COUNT; n++) a1_reg[n] <= '0;
            for (int n = 0; n < HIDDEN_TWO_COUNT; n++) a2_reg[n] <= '0;
        end
        else
        begin
            rv_reg  <= 1'b0;
            vld_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (acc_in && cmd.mode == MODE_PIXEL && cmd.last)
                    begin
                        state_reg <= ST_MAC;
                        lay_reg   <= LAYER_H1;
                        k_reg     <= '0;
                        i_reg     <= '0;
                        acc_reg   <= '0;
                    end
                ST_MAC:
                begin
                    vld_reg <= 1'b1;
                    if (vld_reg) acc_reg <= acc_reg + AW'(prod);
                    if (i_reg == src_cnt - SB'(1))
                        state_reg <= ST_DRN;
                    else
                        i_reg <= i_reg + SB'(1);
                end
                ST_DRN:
                begin
                    if (vld_reg) acc_reg <= acc_reg + AW'(prod);
                    state_reg <= ST_WB;
                end
                ST_WB:
                begin
                    acc_reg <= '0;
                    i_reg   <= '0;
                    if (lay_reg == LAYER_OUT)
                        z_reg[CB'(k_reg)] <= rsum;
                    else if (lay_reg == LAYER_H1)
                        a1_reg[H1B'(k_reg)] <= relu_v;
                    else
                        a2_reg[H2B'(k_reg)] <= relu_v;
                    state_reg <= ST_MAC;
                    if (k_reg == dst_cnt - NB'(1))
                    begin
                        k_reg <= '0;
                        if (lay_reg == LAYER_OUT)
                        begin
                            state_reg <= ST_MAX;
                            c_reg     <= '0;
                        end
                        else
                            lay_reg <= lay_reg + 2'd1;
                    end
                    else
                        k_reg <= k_reg + NB'(1);
                end
                ST_MAX:
                begin
                    if (c_reg == '0 || z_reg[c_reg] > zmax_reg)
                        zmax_reg <= z_reg[c_reg];
                    if (c_reg == CB'(CLASS_COUNT - 1))
                    begin
                        c_reg     <= '0;
                        tot_reg   <= '0;
                        state_reg <= ST_EXP1;
                    end
                    else
                        c_reg <= c_reg + CB'(1);
                end
                ST_EXP1:
                begin
                    if (tprod[AW+13:24] >= (AW-10)'(17 * 4096)) t_reg <= 17'h1FFFF;
                    else                                      t_reg <= tprod[40:24];
                    state_reg <= ST_EXP2;
                end
                ST_EXP2:
                begin
                    if (t_reg[16:12] >= 5'd17)
                    begin
                        e_reg[c_reg] <= '0;
                    end
                    else
                    begin
                        e_reg[c_reg] <= ev >> t_reg[16:12];
                        tot_reg <= tot_reg + 36'(ev >> t_reg[16:12]);
                    end
                    if (c_reg == CB'(CLASS_COUNT - 1))
                    begin
                        c_reg     <= '0;
                        state_reg <= ST_DIV;
                    end
                    else
                    begin
                        c_reg     <= c_reg + CB'(1);
                        state_reg <= ST_EXP1;
                    end
                end
                ST_DIV:
                    state_reg <= ST_DWT;
                ST_DWT:
                    if (drsp.done)
                    begin
                        p_reg   <= (drsp.quo > 17'd65535) ? 16'hFFFF : drsp.quo[15:0];
                        rv_reg  <= 1'b1;
                        ci_reg  <= c_reg;
                        fin_reg <= (c_reg == CB'(CLASS_COUNT - 1));
                        if (c_reg == CB'(CLASS_COUNT - 1))
                            state_reg <= ST_OUT;
                        else
                        begin
                            c_reg     <= c_reg + CB'(1);
                            state_reg <= ST_DIV;
                        end
                    end
                ST_OUT:
                    state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign dreq.go  = (state_reg == ST_DIV);
    assign dreq.num = 32'(e_reg[c_reg]);
    assign dreq.den = tot_reg;

    mlp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign busy            = (state_reg != ST_IDLE);
    assign res_valid       = rv_reg;
    assign res.class_index = 4'(ci_reg);
    assign res.probability = p_reg;
    assign res.final_res   = fin_reg;

`ifndef SYNTHESIS
    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $past(busy)) else $error("result outside a pass");
    a_final_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.final_res) |=> !res_valid) else $error("result after final");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        dreq.go |-> state_reg == ST_DIV) else $error("divider started off sequence");
`endif
endmodule
